### rtl/core/jsu_pkg.sv
// Package for the JSON string unescape block.
// Holds byte codes, mode and result kind types, the hex digit decoder and the
// step result struct. No dependencies.
package jsu_pkg;

  // Byte codes that the escape decoder recognizes.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // Control letters produced by the short escapes.
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Parser mode: plain, after a backslash, or inside a \u escape with
  // zero to three hex digits already collected.
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_HEX2  = 3'd4,
    MODE_HEX3  = 3'd5
  } mode_e;

  // Result kind.
  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_HEX    = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // Outcome of decoding one byte against the current state.
  typedef struct packed {
    logic         emit;
    kind_e        kind;
    logic [7:0]   letter;
    logic [15:0]  code_unit;
    mode_e        mode_next;
    logic [11:0]  accum_next;
  } step_t;

  // Hex digit value; bit 4 is set when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b0, 4'(b - 8'h57)};
    end
    return v;
  endfunction

endpackage

### rtl/core/jsu_if.sv
// Stream interfaces for the JSON string unescape block: the byte channel in
// and the result channel out. Depends on no package.
interface jsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  letter;
  logic [15:0] code_unit;

  modport source (output valid, output kind, output letter, output code_unit,
                  input ready);
  modport sink   (input valid, input kind, input letter, input code_unit,
                  output ready);
endinterface

### rtl/core/jsu_step.sv
// Single-byte decode step of the JSON string unescape block.
// Pure combinational logic from the current mode, the hex accumulator and one
// byte to the result and next state. Depends on jsu_pkg.
module jsu_step (
  input  jsu_pkg::mode_e       mode_i,
  input  logic [11:0]          accum_i,
  input  logic [7:0]           byte_i,
  output jsu_pkg::step_t       step_o
);
  import jsu_pkg::*;

  logic [4:0] digit;
  logic       in_hex;

  assign digit  = hex_value(byte_i);
  assign in_hex = (mode_i == MODE_HEX0) || (mode_i == MODE_HEX1) ||
                  (mode_i == MODE_HEX2) || (mode_i == MODE_HEX3);

  // Decode the byte according to the parser mode.
  always_comb begin
    step_o            = '0;
    step_o.kind       = KIND_LETTER;
    step_o.mode_next  = MODE_PLAIN;
    step_o.accum_next = accum_i;

    if (mode_i == MODE_ESC) begin
      step_o.emit = 1'b1;
      case (byte_i) inside
        CH_QUOTE, CH_BSLASH, CH_SLASH: step_o.letter = byte_i;
        CH_LOW_B: step_o.letter = CTL_BS;
        CH_LOW_F: step_o.letter = CTL_FF;
        CH_LOW_N: step_o.letter = CTL_LF;
        CH_LOW_R: step_o.letter = CTL_CR;
        CH_LOW_T: step_o.letter = CTL_HT;
        CH_LOW_U: begin
          // Open a \u escape; nothing is reported yet.
          step_o.emit       = 1'b0;
          step_o.mode_next  = MODE_HEX0;
          step_o.accum_next = '0;
        end
        default: step_o.kind = KIND_ERROR;
      endcase
    end else if (in_hex) begin
      if (digit[4]) begin
        // Not a hex digit: report an error and drop the partial code unit.
        step_o.emit       = 1'b1;
        step_o.kind       = KIND_ERROR;
        step_o.accum_next = '0;
      end else if (mode_i == MODE_HEX3) begin
        step_o.emit       = 1'b1;
        step_o.kind       = KIND_HEX;
        step_o.code_unit  = {accum_i, digit[3:0]};
        step_o.accum_next = '0;
      end else begin
        step_o.accum_next = {accum_i[7:0], digit[3:0]};
        unique case (mode_i)
          MODE_HEX0: step_o.mode_next = MODE_HEX1;
          MODE_HEX1: step_o.mode_next = MODE_HEX2;
          default:   step_o.mode_next = MODE_HEX3;
        endcase
      end
    end else begin
      // Plain state; unused mode codes behave the same way.
      step_o.emit = 1'b1;
      case (byte_i)
        CH_QUOTE:  step_o.kind = KIND_DONE;
        CH_BSLASH: begin
          step_o.emit      = 1'b0;
          step_o.mode_next = MODE_ESC;
        end
        default:   step_o.letter = byte_i;
      endcase
    end
  end

endmodule

### rtl/core/json_string_unescape.sv
// Top level of the JSON string unescape block.
// Depends on jsu_pkg, the stream interfaces in jsu_if and jsu_step.

// Takes one byte of a JSON string body per clock, starting after the opening
// quote, and gives at most one result per byte: a plain or escaped letter, a
// 16-bit code unit after the four hex digits of a \u escape, a done result for
// the closing quote, or an error for an unknown escape or a non-hex digit
// (after which the parser is back in the plain state). A byte passes an input
// register and a result register; the mode register is updated in the same
// cycle as the decode, so the block sustains one byte per clock as long as
// results are taken.
module json_string_unescape (
  input  logic               clk_i,
  input  logic               rst_ni,
  jsu_byte_if.sink           in_i,
  jsu_result_if.source       out_o
);
  import jsu_pkg::*;

  logic        in_vld_q;
  logic [7:0]  byte_q;
  mode_e       mode_q, mode_d;
  logic [11:0] accum_q, accum_d;
  logic        out_vld_q, out_vld_d;
  kind_e       kind_q;
  logic [7:0]  letter_q;
  logic [15:0] unit_q;
  step_t       step;
  logic        advance;
  logic        in_ready;

  // Decode of the registered byte.
  jsu_step u_step (
    .mode_i  (mode_q),
    .accum_i (accum_q),
    .byte_i  (byte_q),
    .step_o  (step)
  );

  // The held byte moves on once the result register is free or being emptied.
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;
  assign in_i.ready = in_ready;

  // Next state and result valid.
  always_comb begin
    mode_d    = mode_q;
    accum_d   = accum_q;
    out_vld_d = out_vld_q && !out_o.ready;
    if (advance) begin
      mode_d    = step.mode_next;
      accum_d   = step.accum_next;
      out_vld_d = step.emit;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_PLAIN;
      accum_q   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_i.valid;
      end
      out_vld_q <= out_vld_d;
      mode_q    <= mode_d;
      accum_q   <= accum_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      byte_q <= in_i.in_byte;
    end
    if (advance) begin
      kind_q   <= step.kind;
      letter_q <= step.letter;
      unit_q   <= step.code_unit;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.kind      = kind_q;
  assign out_o.letter    = letter_q;
  assign out_o.code_unit = unit_q;

  // The accumulator is only nonzero while inside a \u escape.
  a_accum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_PLAIN || mode_q == MODE_ESC) |-> accum_q == '0)
    else $error("hex accumulator not clear outside a \\u escape");

  // A letter field is zero on every result that is not a letter.
  a_letter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q != KIND_LETTER) |-> letter_q == '0)
    else $error("letter set on a non-letter result");

  // A code unit field is zero on every result that is not a code unit.
  a_unit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q != KIND_HEX) |-> unit_q == '0)
    else $error("code unit set on a non-hex result");

  // A held byte that cannot move on keeps its value and the parser state.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> ($stable(byte_q) && $stable(mode_q)))
    else $error("stalled byte or mode changed");

endmodule

### tb/sv/json_string_unescape_tb.sv
// Testbench for json_string_unescape: sends JSON string body bytes and checks
// each decoded result against a local model of the escape parser.
// Depends on jsu_pkg and the stream interfaces in jsu_if.
module json_string_unescape_tb;
  import jsu_pkg::*;

  // One decoded result as the block reports it.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  letter;
    logic [15:0] code_unit;
  } unescaped_t;

  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jsu_byte_if   byte_ch ();
  jsu_result_if res_ch ();

  json_string_unescape dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  // Results the parser model has predicted but the block has not yet given.
  unescaped_t  pending_results[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  // Parser model state.
  mode_e       parse_mode = MODE_PLAIN;
  logic [11:0] hex_so_far = '0;

  always #1 clk = ~clk;

  // Value of a hex digit byte; bit 4 is set for any other byte.
  function automatic logic [4:0] digit_of(input logic [7:0] b);
    logic [4:0] val;
    val = 5'h10;
    if (b >= "0" && b <= "9") begin
      val = {1'b0, b[3:0]};
    end else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
      val = {1'b0, b[3:0] + 4'd9};
    end
    return val;
  endfunction

  function automatic void queue_result(input kind_e k, input logic [7:0] l,
                                       input logic [15:0] u);
    unescaped_t r;
    r.kind = k;
    r.letter = l;
    r.code_unit = u;
    pending_results.push_back(r);
  endfunction

  // Advances the parser model by one byte and queues the result it causes.
  function automatic void decode_byte(input logic [7:0] b);
    logic [4:0] d;
    case (parse_mode)
      MODE_ESC: begin
        parse_mode = MODE_PLAIN;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: queue_result(KIND_LETTER, b, 16'h0);
          CH_LOW_B: queue_result(KIND_LETTER, CTL_BS, 16'h0);
          CH_LOW_F: queue_result(KIND_LETTER, CTL_FF, 16'h0);
          CH_LOW_N: queue_result(KIND_LETTER, CTL_LF, 16'h0);
          CH_LOW_R: queue_result(KIND_LETTER, CTL_CR, 16'h0);
          CH_LOW_T: queue_result(KIND_LETTER, CTL_HT, 16'h0);
          CH_LOW_U: begin
            parse_mode = MODE_HEX0;
            hex_so_far = '0;
          end
          default: queue_result(KIND_ERROR, 8'h0, 16'h0);
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        d = digit_of(b);
        if (d[4]) begin
          // A non-hex byte, a quote included, aborts the escape.
          parse_mode = MODE_PLAIN;
          hex_so_far = '0;
          queue_result(KIND_ERROR, 8'h0, 16'h0);
        end else if (parse_mode == MODE_HEX3) begin
          queue_result(KIND_HEX, 8'h0, {hex_so_far, d[3:0]});
          parse_mode = MODE_PLAIN;
          hex_so_far = '0;
        end else begin
          hex_so_far = {hex_so_far[7:0], d[3:0]};
          parse_mode = mode_e'(parse_mode + 3'd1);
        end
      end
      default: begin
        parse_mode = MODE_PLAIN;
        if (b == CH_QUOTE) begin
          queue_result(KIND_DONE, 8'h0, 16'h0);
        end else if (b == CH_BSLASH) begin
          parse_mode = MODE_ESC;
        end else begin
          queue_result(KIND_LETTER, b, 16'h0);
        end
      end
    endcase
  endfunction

  // Sends one byte, idling first at random, and predicts once it is taken.
  // Valid stays high afterwards so that back-to-back items need no gap.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Hex digit character for a value, in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = "0" + {4'd0, v};
    end else begin
      c = (($urandom_range(0, 1) != 0) ? "A" : "a") + {4'd0, v} - 8'd10;
    end
    return c;
  endfunction

  task automatic send_hex_escape(input logic [15:0] unit);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_U);
    for (int i = 3; i >= 0; i--) begin
      send_byte(hex_char(unit[i*4 +: 4]));
    end
  endtask

  function automatic logic [7:0] short_escape_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CH_QUOTE;
      1: c = CH_BSLASH;
      2: c = CH_SLASH;
      3: c = CH_LOW_B;
      4: c = CH_LOW_F;
      5: c = CH_LOW_N;
      6: c = CH_LOW_R;
      default: c = CH_LOW_T;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] unknown_escape_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LOW_B ||
               c == CH_LOW_F || c == CH_LOW_N || c == CH_LOW_R || c == CH_LOW_T ||
               c == CH_LOW_U);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] d;
    if ($urandom_range(0, 3) == 0) begin
      c = CH_QUOTE;
    end else begin
      do begin
        c = 8'($urandom_range(0, 255));
        d = digit_of(c);
      end while (!d[4]);
    end
    return c;
  endfunction

  // One random piece of a string body: mostly well-formed escapes and letters,
  // with some broken escapes and stray bytes mixed in.
  task automatic send_random_piece();
    int pick;
    int digits;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 57) begin
      send_byte(CH_BSLASH);
      send_byte(short_escape_char());
    end else if (pick < 80) begin
      send_hex_escape(16'($urandom_range(0, 65535)));
    end else if (pick < 88) begin
      // Escape cut short by a non-hex byte after zero to three digits.
      digits = $urandom_range(0, 3);
      send_byte(CH_BSLASH);
      send_byte(CH_LOW_U);
      repeat (digits) send_byte(hex_char(4'($urandom_range(0, 15))));
      send_byte(non_hex_char());
    end else if (pick < 94) begin
      send_byte(CH_BSLASH);
      send_byte(unknown_escape_char());
    end else begin
      send_byte(CH_QUOTE);
    end
  endtask

  // Extreme letters and the closing quote.
  task automatic test_plain_and_done();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
  endtask

  task automatic test_short_escapes();
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_N);
    send_byte(CH_BSLASH);
    send_byte(CH_QUOTE);
  endtask

  // Four digits in mixed case, largest and smallest digit values.
  task automatic test_unicode_escape();
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_U);
    send_byte("F");
    send_byte("f");
    send_byte("a");
    send_byte("0");
  endtask

  // Unknown escape, and a quote where a hex digit belongs.
  task automatic test_bad_escapes();
    send_byte(CH_BSLASH);
    send_byte("x");
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_U);
    send_byte(CH_QUOTE);
  endtask

  task automatic test_random_traffic(input int count, input int src_pct,
                                     input int sink_pct);
    int start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      send_random_piece();
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic report_field(input string name, input logic [15:0] want_val,
                              input logic [15:0] got_val);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_val, got_val);
    fail_count++;
  endtask

  // Result checker and random receiver stalls.
  always @(posedge clk) begin : check_results
    unescaped_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %h letter %h unit %h",
                 $time, res_ch.kind, res_ch.letter, res_ch.code_unit);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.kind !== want.kind) report_field("kind", 16'(want.kind), 16'(res_ch.kind));
        if (res_ch.letter !== want.letter) begin
          report_field("letter", 16'(want.letter), 16'(res_ch.letter));
        end
        if (res_ch.code_unit !== want.code_unit) begin
          report_field("code_unit", want.code_unit, res_ch.code_unit);
        end
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_and_done();
    test_short_escapes();
    test_unicode_escape();
    test_bad_escapes();
    wait_drained();

    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 69, 0);
    test_random_traffic(450, 0, 69);
    test_random_traffic(450, 24, 24);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/jsu_step.sv
rtl/core/json_string_unescape.sv
tb/sv/json_string_unescape_tb.sv
